>>> sv/ssp_fb_pkg.sv
// ----------------------------------------------------------------------------
// ssp_fb_pkg: shared types, constants and a function of the frame builder
// Holds the framing constants, the CRC-16 byte update, the message phase
// type and the result group that passes from the parser to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_fb_pkg;

  // Framing and sync constants.
  localparam logic [7:0]  START_BYTE = 8'h7F;
  localparam logic [7:0]  SYNC_B0    = 8'h80;
  localparam logic [7:0]  SYNC_B1    = 8'h01;
  localparam logic [7:0]  SYNC_B2    = 8'h11;
  localparam logic [7:0]  SEQ_FLAG   = 8'h80;
  localparam logic [7:0]  ZERO_FLAG  = 8'h00;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Most data bytes that one input transfer can release.
  localparam int unsigned MAX_DATA   = 3;

  // Position of the incoming byte within its message.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_BODY
  } phase_t;

  // What the emitter is currently sending.
  typedef enum logic [1:0] {
    K_START,
    K_DATA,
    K_CRC_LO,
    K_CRC_HI
  } kind_t;

  // Results released by one input transfer, in order:
  // start byte, data bytes, then the two CRC bytes.
  typedef struct packed {
    logic                       has_start;
    logic [MAX_DATA-1:0][7:0]   data;
    logic [1:0]                 ndata;
    logic                       has_crc;
  } group_t;

  // CRC-16 with polynomial 0x8005, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

`default_nettype wire

>>> sv/ssp_fb_in_if.sv
// ----------------------------------------------------------------------------
// ssp_fb_in_if: message byte channel
// Valid/ready channel that carries one command message byte and its
// last-byte marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_fb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, output msg_byte, output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> sv/ssp_fb_out_if.sv
// ----------------------------------------------------------------------------
// ssp_fb_out_if: frame byte channel
// Valid/ready channel that carries one outgoing frame byte and the
// end-of-frame marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

>>> sv/ssp_fb_parse.sv
// ----------------------------------------------------------------------------
// ssp_fb_parse: message parser
// Tracks the byte position within the message, holds back the first two
// bytes until sync can be decided, and builds the group of frame bytes that
// each accepted message byte releases. Owns the sequence bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_fb_parse (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  wire  [7:0]          msg_byte,
  input  wire                 last_byte,
  output ssp_fb_pkg::group_t  grp
);
  import ssp_fb_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       seq_r, seq_nxt;
  logic       sync_r, sync_nxt;
  logic [7:0] held0_r, held1_r;
  logic [7:0] flag;
  logic       sync_now;
  logic       sync_end;

  assign flag     = seq_r ? SEQ_FLAG : ZERO_FLAG;
  assign sync_now = (held0_r == SYNC_B0) && (held1_r == SYNC_B1) && (msg_byte == SYNC_B2);

  // Build the result group and the next message state.
  always_comb begin
    grp           = '0;
    grp.has_crc   = last_byte;
    phase_nxt     = phase_r;
    sync_nxt      = sync_r;
    sync_end      = 1'b0;
    case (phase_r)
      PH_FIRST: begin
        grp.has_start = 1'b1;
        grp.data[0]   = flag;
        grp.ndata     = last_byte ? 2'd1 : 2'd0;
        sync_nxt      = 1'b0;
        phase_nxt     = PH_SECOND;
      end
      PH_SECOND: begin
        grp.data[0]   = flag;
        grp.data[1]   = msg_byte;
        grp.ndata     = last_byte ? 2'd2 : 2'd0;
        phase_nxt     = PH_THIRD;
      end
      PH_THIRD: begin
        grp.data[0]   = sync_now ? held0_r : flag;
        grp.data[1]   = held1_r;
        grp.data[2]   = msg_byte;
        grp.ndata     = 2'd3;
        sync_nxt      = sync_now;
        sync_end      = sync_now;
        phase_nxt     = PH_BODY;
      end
      PH_BODY: begin
        grp.data[0]   = msg_byte;
        grp.ndata     = 2'd1;
        sync_end      = sync_r;
      end
      default: begin
        phase_nxt     = PH_FIRST;
      end
    endcase
    seq_nxt = seq_r;
    // Frame end: a sync clears the sequence bit, anything else toggles it.
    if (last_byte) begin
      seq_nxt   = sync_end ? 1'b0 : ~seq_r;
      phase_nxt = PH_FIRST;
      sync_nxt  = 1'b0;
    end
  end

  // Message state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      seq_r   <= 1'b1;
      sync_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      sync_r  <= sync_nxt;
    end
  end

  // Held message bytes, written before they are ever read.
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_FIRST)) begin
      held0_r <= msg_byte;
    end
    if (accept && (phase_r == PH_SECOND)) begin
      held1_r <= msg_byte;
    end
  end

  // A sync decision only stands once the third byte has passed.
  a_sync_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    sync_r |-> (phase_r == PH_BODY))
    else $error("sync flag set outside the message body");

  // The message ends on its last byte.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> (phase_r == PH_FIRST))
    else $error("message did not restart after its last byte");

  // A one-byte message releases start, flag and CRC.
  a_short_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte && (phase_r == PH_FIRST)) |->
      (grp.has_start && grp.has_crc && (grp.ndata == 2'd1)))
    else $error("one-byte message built a wrong group");

endmodule

`default_nettype wire

>>> sv/ssp_fb_emit.sv
// ----------------------------------------------------------------------------
// ssp_fb_emit: frame byte emitter
// Registers one result group and sends its bytes one per transfer. The
// running CRC is updated on each data byte as it leaves and sent low byte
// first at the end of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_fb_emit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  ssp_fb_pkg::group_t  grp,
  output logic                can_load,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic                out_end
);
  import ssp_fb_pkg::*;

  group_t      grp_r;
  logic        busy_r;
  logic [2:0]  pos_r;
  logic [2:0]  total_r;
  logic [15:0] crc_r;
  logic [2:0]  total_w;
  logic [2:0]  dpos;
  kind_t       kind;
  logic        xfer;
  logic        last_xfer;

  // Number of bytes in the incoming group.
  assign total_w = {2'b00, grp.has_start} + {1'b0, grp.ndata} + {1'b0, grp.has_crc, 1'b0};

  assign xfer      = busy_r && out_ready;
  assign last_xfer = xfer && (pos_r == (total_r - 3'd1));
  assign can_load  = !busy_r || last_xfer;

  // Decode what the current position holds.
  assign dpos = pos_r - {2'b00, grp_r.has_start};
  always_comb begin
    if (grp_r.has_start && (pos_r == 3'd0)) begin
      kind = K_START;
    end else if (dpos < {1'b0, grp_r.ndata}) begin
      kind = K_DATA;
    end else if (dpos == {1'b0, grp_r.ndata}) begin
      kind = K_CRC_LO;
    end else begin
      kind = K_CRC_HI;
    end
  end

  // Output byte selection.
  always_comb begin
    case (kind)
      K_START:  out_byte = START_BYTE;
      K_DATA:   out_byte = grp_r.data[dpos[1:0]];
      K_CRC_LO: out_byte = crc_r[7:0];
      K_CRC_HI: out_byte = crc_r[15:8];
      default:  out_byte = START_BYTE;
    endcase
  end

  assign out_valid = busy_r;
  assign out_end   = (kind == K_CRC_HI);

  // Group register and position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pos_r   <= '0;
      total_r <= '0;
    end else if (load) begin
      busy_r  <= (total_w != 3'd0);
      pos_r   <= '0;
      total_r <= total_w;
    end else if (xfer) begin
      busy_r  <= !last_xfer;
      pos_r   <= pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

  // Running CRC over the data bytes sent after the start byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else if (xfer) begin
      case (kind)
        K_START:  crc_r <= CRC_INIT;
        K_DATA:   crc_r <= crc16_byte(crc_r, out_byte);
        K_CRC_HI: crc_r <= CRC_INIT;
        default:  crc_r <= crc_r;
      endcase
    end
  end

  // The position never runs past the group while bytes are pending.
  a_pos_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r < total_r))
    else $error("emitter position beyond its group");

  // The CRC high byte is always the final byte of its group.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_end) |-> (pos_r == (total_r - 3'd1)))
    else $error("frame end not on the last byte of a group");

  // After a frame ends the CRC is back at its initial value.
  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && out_end) |=> (crc_r == CRC_INIT))
    else $error("CRC not restarted after frame end");

endmodule

`default_nettype wire

>>> sv/ssp_frame_builder_crc16_core.sv
// ----------------------------------------------------------------------------
// ssp_frame_builder_crc16_core: framed command output with CRC-16
// Turns a stream of command message bytes into outgoing frames.
//
// Input channel (in_chan): one message byte per transfer, last_byte set on
// the final byte of a message. Output channel (out_chan): one frame byte per
// transfer; frame_end marks the high CRC byte that closes a frame.
// A frame is 7F, the message (first byte replaced by the sequence flag
// unless the message is the 80 01 11 sync), and CRC-16 0x8005 low byte first.
// The first frame byte caused by an input transfer is valid the cycle after
// that transfer. An input transfer releases 0 to 5 frame bytes; the output
// side sends them from the registered group, one byte per cycle while the
// receiver is ready. A new input transfer is taken in the same cycle as the
// last byte of the previous group leaves, so with the receiver ready a long
// message moves at one byte per cycle.
// When the receiver stalls, the current byte holds and input ready stays
// low until the last byte of the current group has been transferred.
// Reset: the sequence flag starts at 0x80, no frame is in progress, the
// output channel is empty and input ready is low while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_frame_builder_crc16_core (
  input  wire          clk,
  input  wire          rst_n,
  ssp_fb_in_if.sink    in_chan,
  ssp_fb_out_if.source out_chan
);
  import ssp_fb_pkg::*;

  group_t grp;
  logic   can_load;
  logic   in_accept;

  // No input transfer is taken while reset is held.
  assign in_chan.ready = can_load && rst_n;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Message parsing and sequence handling.
  ssp_fb_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .msg_byte  (in_chan.msg_byte),
    .last_byte (in_chan.last_byte),
    .grp       (grp)
  );

  // Byte-by-byte emission with running CRC.
  ssp_fb_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.frame_byte),
    .out_end   (out_chan.frame_end)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the SSP frame builder with CRC-16
// Sends command messages byte by byte and checks every outgoing frame byte
// against a local prediction of the frame: start byte, sequence flag or sync
// bytes, message body and CRC-16. A short table of directed messages comes
// first, then random messages with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import ssp_fb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS  = 106;
  localparam int unsigned MAX_PRINTS  = 40;

  // One outgoing frame byte as the receiver sees it.
  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
  } frame_beat_t;

  // One directed transfer. Where typed is set, the frame bytes it releases
  // are listed in fb (none of them ends a frame).
  typedef struct packed {
    logic [7:0]      mb;
    logic            lb;
    logic            typed;
    logic [2:0]      n;
    logic [0:4][7:0] fb;
  } stim_row_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_CADENCE,
    RX_LONG
  } rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ssp_fb_in_if  in_chan ();
  ssp_fb_out_if out_chan ();

  ssp_frame_builder_crc16_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the frame builder.
  logic       seq_hi;
  logic [15:0] run_crc;
  logic [7:0] held_b [2];
  phase_t     msg_phase;
  logic       sync_seen;

  frame_beat_t pending_frame [$];
  frame_beat_t step_bytes [$];
  frame_beat_t head_beat;

  int unsigned err_cnt      = 0;
  int unsigned items_sent   = 0;
  int unsigned beats_seen   = 0;
  int unsigned frames_seen  = 0;
  int unsigned sync_frames  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 0;
  logic        steady       = 1'b0;

  // Directed messages: single byte, two bytes, sync with body, sync ending
  // on its third byte, near misses of the sync pattern, and a message whose
  // flagged first bytes look exactly like a sync.
  stim_row_t dir_tbl [24] = '{
    '{8'hFF, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h00, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'hFF, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h80, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h01, 1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h11, 1'b0, 1'b1, 3'd3, {SYNC_B0, SYNC_B1, SYNC_B2, 16'h0}},
    '{8'hAA, 1'b0, 1'b1, 3'd1, {8'hAA, 32'h0}},
    '{8'h55, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h80, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h01, 1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h11, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h80, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h01, 1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h10, 1'b0, 1'b1, 3'd3, {ZERO_FLAG, 8'h01, 8'h10, 16'h0}},
    '{8'h00, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h80, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h01, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h80, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h00, 1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h11, 1'b1, 1'b0, 3'd0, 40'h0},
    '{8'h81, 1'b0, 1'b1, 3'd1, {START_BYTE, 32'h0}},
    '{8'h01, 1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h11, 1'b0, 1'b1, 3'd3, {SEQ_FLAG, SYNC_B1, SYNC_B2, 16'h0}},
    '{8'hFF, 1'b1, 1'b0, 3'd0, 40'h0}
  };

  // Receiver ready, changed at the falling edge.
  logic       rx_ready = 1'b0;
  rx_mode_t   rx_mode  = RX_OPEN;
  logic [5:0] rx_tick  = 6'd0;

  assign out_chan.ready = rx_ready;

  // Prints one line per failure, up to a limit, and counts them all.
  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // CRC-16 update, polynomial 0x8005, one message bit at a time, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function void note_beat(input logic [7:0] b, input logic e);
    frame_beat_t beat;
    beat.fbyte = b;
    beat.fend  = e;
    step_bytes.push_back(beat);
  endfunction

  // A byte that is covered by the CRC.
  function void note_data(input logic [7:0] b);
    run_crc = crc_update(run_crc, b);
    note_beat(b, 1'b0);
  endfunction

  function logic [7:0] seq_byte();
    return seq_hi ? SEQ_FLAG : ZERO_FLAG;
  endfunction

  function void reset_frame_state();
    seq_hi    = 1'b1;
    run_crc   = CRC_INIT;
    held_b[0] = 8'h00;
    held_b[1] = 8'h00;
    msg_phase = PH_FIRST;
    sync_seen = 1'b0;
  endfunction

  // Frame bytes released by one accepted message byte, left in step_bytes.
  function void frame_step(input logic [7:0] b, input logic lst);
    step_bytes.delete();
    case (msg_phase)
      PH_FIRST: begin
        held_b[0] = b;
        run_crc   = CRC_INIT;
        sync_seen = 1'b0;
        note_beat(START_BYTE, 1'b0);
        if (lst) begin
          note_data(seq_byte());
        end
        msg_phase = PH_SECOND;
      end
      PH_SECOND: begin
        held_b[1] = b;
        if (lst) begin
          note_data(seq_byte());
          note_data(b);
        end
        msg_phase = PH_THIRD;
      end
      PH_THIRD: begin
        // The held bytes are released once the sync check is decided.
        if (held_b[0] == SYNC_B0 && held_b[1] == SYNC_B1 && b == SYNC_B2) begin
          sync_seen = 1'b1;
          note_data(held_b[0]);
        end else begin
          sync_seen = 1'b0;
          note_data(seq_byte());
        end
        note_data(held_b[1]);
        note_data(b);
        msg_phase = PH_BODY;
      end
      default: begin
        note_data(b);
      end
    endcase

    // Closing CRC, low byte first; a sync clears the sequence bit.
    if (lst) begin
      note_beat(run_crc[7:0], 1'b0);
      note_beat(run_crc[15:8], 1'b1);
      if (sync_seen) begin
        sync_frames++;
      end
      seq_hi    = sync_seen ? 1'b0 : ~seq_hi;
      msg_phase = PH_FIRST;
      run_crc   = CRC_INIT;
      sync_seen = 1'b0;
    end
  endfunction

  // Sender idle cycles with valid low.
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
  endtask

  // Drives one message byte until its transfer, then records what it must
  // release. Typed rows take the listed bytes instead of the prediction.
  task automatic send_item(input logic [7:0] b, input logic lst, input logic typed,
                           input logic [2:0] n, input logic [0:4][7:0] fb);
    frame_beat_t beat;
    if (burst_left == 0) begin
      if (!steady) begin
        idle_cycles($urandom_range(0, 5));
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.msg_byte  <= b;
    in_chan.last_byte <= lst;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
    burst_left--;
    items_sent++;
    frame_step(b, lst);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        beat.fbyte = fb[i];
        beat.fend  = 1'b0;
        pending_frame.push_back(beat);
      end
    end else begin
      foreach (step_bytes[i]) begin
        pending_frame.push_back(step_bytes[i]);
      end
    end
  endtask

  // Holds the sender off until every predicted frame byte has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pending_frame.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One random message: mostly ordinary messages of short length, some
  // syncs, near misses of the sync pattern, and a few long ones.
  task automatic send_random_message();
    logic [7:0]  msg [$];
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    int unsigned j;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      len = 1;
    end else if (pick < 24) begin
      len = 2;
    end else if (pick < 44) begin
      len = 3;
    end else if (pick < 92) begin
      len = $urandom_range(4, 8);
    end else begin
      len = $urandom_range(9, 16);
    end
    for (int i = 0; i < len; i++) begin
      msg.push_back(8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (len >= 3 && pick < 30) begin
      msg[0] = SYNC_B0;
      msg[1] = SYNC_B1;
      msg[2] = SYNC_B2;
      // Near miss: one bit of the sync pattern flipped.
      if (pick >= 20) begin
        k = $urandom_range(0, 2);
        j = $urandom_range(0, 7);
        msg[k] = msg[k] ^ (8'h01 << j);
      end
    end else if (len < 3 && pick < 30) begin
      msg[0] = SYNC_B0;
      if (len == 2) begin
        msg[1] = SYNC_B1;
      end
    end
    steady = ($urandom_range(0, 4) == 0);
    foreach (msg[i]) begin
      send_item(msg[i], (i == len - 1), 1'b0, 3'd0, 40'h0);
    end
  endtask

  // Receiver stall pattern, reselected each time the 6-bit tick counter wraps.
  always @(negedge clk) begin
    if (rx_tick == 6'd0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    rx_tick <= rx_tick + 6'd1;
    case (rx_mode)
      RX_OPEN:    rx_ready <= 1'b1;
      RX_RANDOM:  rx_ready <= ($urandom_range(0, 3) != 0);
      RX_CADENCE: rx_ready <= (rx_tick % 3 != 0);
      default:    rx_ready <= (rx_tick[2:0] < 3'd3);
    endcase
  end

  // Frame byte checker: each transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_frame.size() == 0) begin
        flag_error($sformatf("unexpected frame byte %02h end %0b",
                             out_chan.frame_byte, out_chan.frame_end));
      end else begin
        head_beat = pending_frame.pop_front();
        beats_seen++;
        if (out_chan.frame_byte !== head_beat.fbyte) begin
          flag_error($sformatf("frame byte %0d: got %02h, want %02h", beats_seen,
                               out_chan.frame_byte, head_beat.fbyte));
        end
        if (out_chan.frame_end !== head_beat.fend) begin
          flag_error($sformatf("frame byte %0d: frame_end %0b, want %0b", beats_seen,
                               out_chan.frame_end, head_beat.fend));
        end
        if (head_beat.fend) begin
          frames_seen++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame bytes outstanding",
               cycle_cnt, pending_frame.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random messages, then drain.
  initial begin
    int unsigned rand_start;
    in_chan.valid     = 1'b0;
    in_chan.msg_byte  = 8'h00;
    in_chan.last_byte = 1'b0;
    reset_frame_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].mb, dir_tbl[i].lb, dir_tbl[i].typed, dir_tbl[i].n,
                dir_tbl[i].fb);
    end
    wait_drained();

    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      send_random_message();
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end

    // Let the last frame leave, then watch for stray bytes.
    wait_drained();
    repeat (16) @(posedge clk);
    if (pending_frame.size() != 0) begin
      flag_error($sformatf("%0d frame bytes never arrived", pending_frame.size()));
    end

    $display("sent %0d message bytes; checked %0d frame bytes in %0d frames, %0d of them sync",
             items_sent, beats_seen, frames_seen, sync_frames);
    $display("errors: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> ssp_frame_builder_crc16_core.f
sv/ssp_fb_pkg.sv
sv/ssp_fb_in_if.sv
sv/ssp_fb_out_if.sv
sv/ssp_fb_parse.sv
sv/ssp_fb_emit.sv
sv/ssp_frame_builder_crc16_core.sv
tb/sv/tb.sv
